FILE: src/rvcl_pkg.sv
package rvcl_pkg;

  // container layout
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned CHUNK_HDR_BYTES = 8;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WEBP = 32'h5745_4250;
  localparam logic [31:0] TAG_VP8  = 32'h5650_3820;

  // smallest accepted riff payload size (room for the webp tag)
  localparam logic [31:0] MIN_PAYLOAD = 32'd4;

  localparam int unsigned POS_W = 34;
  localparam int unsigned SIZE_W = 33;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_WALK,
    PH_MATCHED,
    PH_FAILED,
    PH_ENDED
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic              found;
    logic [SIZE_W-1:0] chunk_offset;
    logic [SIZE_W-1:0] chunk_length;
  } out_beat_t;

endpackage

FILE: src/riff_vp8_chunk_locator_unit.sv
// channel | direction | handshake          | payload
// --------+-----------+--------------------+---------------------------------------------
// in_     | input     | in_valid / in_stall   | in_data: data_byte, last_byte
// out_    | output    | out_valid / out_stall | out_data: found, chunk_offset, chunk_length
//
// one byte per cycle while in_stall is low; each beat is parsed in the cycle it
// is accepted, and a file's result goes to the output register or skid entry on
// its last byte. 33-bit adds and compares walk the chunks (size, remaining span)
// rst_n is synchronous, active low; it returns the parser to the header state
// a one-entry skid behind the output register keeps the input open while a
// result waits; in_stall rises only when both output entries are full
module riff_vp8_chunk_locator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rvcl_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rvcl_pkg::out_beat_t out_data
);
  import rvcl_pkg::*;

  // parser state
  phase_t              phase_r, phase_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;        // index of the current byte, saturating
  logic [SIZE_W-1:0]   start_r, start_nxt;    // offset of the chunk being walked
  logic [SIZE_W-1:0]   rem_r, rem_nxt;        // container total minus chunk start
  logic [SIZE_W-1:0]   ctm1_r, ctm1_nxt;      // container total minus one
  logic [SIZE_W-1:0]   skip_r, skip_nxt;      // chunk data bytes still to pass over
  logic [2:0]          cnt_r, cnt_nxt;        // byte index inside a chunk header
  logic [31:0]         tag_r, tag_nxt;        // big-endian tag shifter
  logic [31:0]         field_r, field_nxt;    // little-endian size shifter
  logic [SIZE_W-1:0]   moff_r, moff_nxt;
  logic [SIZE_W-1:0]   mlen_r, mlen_nxt;

  // output register and skid
  logic                out_valid_r, out_valid_nxt;
  out_beat_t           out_data_r, out_data_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  out_beat_t           skid_data_r, skid_data_nxt;

  logic                in_acc;
  logic                out_pop;
  logic                res_valid;
  out_beat_t           res;
  logic                ok;
  logic [31:0]         tag_cat;
  logic [31:0]         field_cat;
  logic [SIZE_W-1:0]   padded;
  logic [SIZE_W-1:0]   total;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_pop   = out_valid_r && !out_stall;

  // shifter views that include the current byte
  assign tag_cat   = {tag_r[23:0], in_data.data_byte};
  assign field_cat = {in_data.data_byte, field_r[31:8]};

  // chunk size padded to even, plus the chunk header
  assign padded = {1'b0, field_cat} + SIZE_W'(field_cat[0]);
  assign total  = padded + SIZE_W'(CHUNK_HDR_BYTES);

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    rem_nxt   = rem_r;
    ctm1_nxt  = ctm1_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    tag_nxt   = tag_r;
    field_nxt = field_r;
    moff_nxt  = moff_r;
    mlen_nxt  = mlen_r;
    res_valid = 1'b0;
    ok        = 1'b0;
    res       = '0;

    if (in_acc) begin
      if (pos_r != '1) begin
        pos_nxt = pos_r + POS_W'(1);
      end

      unique case (phase_r)
        PH_HEADER: begin
          // position stays below twelve in this phase
          if (pos_r[3:0] < 4'd4 || pos_r[3:0] >= 4'd8) begin
            tag_nxt = tag_cat;
          end else begin
            field_nxt = field_cat;
          end
          if (pos_r[3:0] == 4'd3 && tag_cat != TAG_RIFF) begin
            phase_nxt = PH_FAILED;
          end else if (pos_r[3:0] == 4'(HEADER_BYTES - 1)) begin
            if (tag_cat != TAG_WEBP || field_r < MIN_PAYLOAD) begin
              phase_nxt = PH_FAILED;
            end else begin
              ctm1_nxt  = {1'b0, field_r} + SIZE_W'(CHUNK_HDR_BYTES - 1);
              rem_nxt   = {1'b0, field_r} - SIZE_W'(HEADER_BYTES - CHUNK_HDR_BYTES);
              // empty container: nothing to walk
              phase_nxt = (field_r > MIN_PAYLOAD) ? PH_WALK : PH_ENDED;
            end
          end
        end
        PH_WALK: begin
          if (skip_r != '0) begin
            skip_nxt = skip_r - SIZE_W'(1);
          end else begin
            cnt_nxt = cnt_r + 3'd1;
            if (!cnt_r[2]) begin
              tag_nxt = tag_cat;
            end else begin
              field_nxt = field_cat;
            end
            if (cnt_r == 3'd7) begin
              if (total > rem_r) begin
                // chunk overruns the container
                phase_nxt = PH_FAILED;
              end else if (tag_r == TAG_VP8) begin
                moff_nxt  = start_r;
                mlen_nxt  = total;
                phase_nxt = PH_MATCHED;
              end else if (total == rem_r) begin
                phase_nxt = PH_ENDED;
              end else begin
                start_nxt = start_r + total;
                rem_nxt   = rem_r - total;
                skip_nxt  = padded;
                cnt_nxt   = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase

      if (in_data.last_byte) begin
        // file length is pos + 1; it must cover the whole container
        ok = (phase_nxt == PH_MATCHED) && (pos_r >= {1'b0, ctm1_r});
        res_valid        = 1'b1;
        res.found        = ok;
        res.chunk_offset = ok ? moff_nxt : '0;
        res.chunk_length = ok ? mlen_nxt : '0;
        // next byte opens a new file
        phase_nxt = PH_HEADER;
        pos_nxt   = '0;
        start_nxt = SIZE_W'(HEADER_BYTES);
        skip_nxt  = '0;
        cnt_nxt   = '0;
      end
    end
  end

  // output register with a skid entry behind it
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && !out_pop) begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end else begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      pos_r        <= '0;
      start_r      <= SIZE_W'(HEADER_BYTES);
      skip_r       <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      start_r      <= start_nxt;
      skip_r       <= skip_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload, always written before it is read
  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    ctm1_r      <= ctm1_nxt;
    tag_r       <= tag_nxt;
    field_r     <= field_nxt;
    moff_r      <= moff_nxt;
    mlen_r      <= mlen_nxt;
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

FILE: src/rvcl_checker.sv
module rvcl_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rvcl_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rvcl_pkg::out_beat_t out_data
);
  import rvcl_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // no find carries zero offset and length
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.chunk_offset == '0 && out_data.chunk_length == '0)
    else $error("miss with nonzero offset or length");

  // a find lies on an even offset past the file header, with an even length of at least 8
  a_find_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.chunk_offset >= SIZE_W'(HEADER_BYTES) && !out_data.chunk_offset[0] &&
      out_data.chunk_length >= SIZE_W'(CHUNK_HDR_BYTES) && !out_data.chunk_length[0])
    else $error("found chunk with impossible offset or length");

  // input backpressure only appears behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall && in_valid && in_data.last_byte))
    else $error("input stalled without a pending result");

endmodule

bind riff_vp8_chunk_locator_unit rvcl_checker u_rvcl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: bench/vp8_locate_checker.sv
`timescale 1ns / 100ps

module vp8_locate_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  rvcl_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  rvcl_pkg::out_beat_t out_data,
  output int                  mismatches,
  output int                  awaiting
);
  import rvcl_pkg::*;

  // parser state mirrored from the container format
  logic [POS_W-1:0]  byte_pos;
  phase_t            walk_state;
  logic [SIZE_W-1:0] riff_total;
  logic [SIZE_W-1:0] chunk_base;
  logic [31:0]       size_acc;
  logic [31:0]       tag_acc;
  logic [SIZE_W-1:0] vp8_offset;
  logic [SIZE_W-1:0] vp8_length;

  out_beat_t located_q[$];

  function automatic void clear_locator();
    byte_pos   = '0;
    walk_state = PH_HEADER;
    riff_total = '0;
    chunk_base = SIZE_W'(HEADER_BYTES);
    size_acc   = '0;
    tag_acc    = '0;
    vp8_offset = '0;
    vp8_length = '0;
  endfunction

  task automatic track_byte(input in_beat_t beat);
    logic [POS_W:0]    file_len;
    logic [POS_W-1:0]  rel;
    logic [SIZE_W-1:0] padded;
    logic [SIZE_W-1:0] span;
    logic [SIZE_W-1:0] room;
    logic [SIZE_W:0]   next_base;
    out_beat_t         res;
    if (walk_state == PH_HEADER) begin
      if (byte_pos < 4 || byte_pos >= 8) tag_acc = {tag_acc[23:0], beat.data_byte};
      else size_acc = {beat.data_byte, size_acc[31:8]};
      if (byte_pos == 3 && tag_acc != TAG_RIFF) begin
        walk_state = PH_FAILED;
      end else if (byte_pos == 11) begin
        if (tag_acc != TAG_WEBP || size_acc < MIN_PAYLOAD) begin
          walk_state = PH_FAILED;
        end else begin
          riff_total = {1'b0, size_acc} + SIZE_W'(CHUNK_HDR_BYTES);
          walk_state = (riff_total > HEADER_BYTES) ? PH_WALK : PH_ENDED;
        end
      end
    end else if (walk_state == PH_WALK && byte_pos >= chunk_base) begin
      rel = byte_pos - {1'b0, chunk_base};
      if (rel <= 7) begin
        if (rel < 4) tag_acc = {tag_acc[23:0], beat.data_byte};
        else size_acc = {beat.data_byte, size_acc[31:8]};
        if (rel == 7) begin
          // data is padded to even, then the 8-byte chunk header is added
          padded = {1'b0, size_acc} + SIZE_W'(size_acc[0]);
          span   = padded + SIZE_W'(CHUNK_HDR_BYTES);
          room   = riff_total - chunk_base;
          if (span > room) begin
            walk_state = PH_FAILED;
          end else if (tag_acc == TAG_VP8) begin
            vp8_offset = chunk_base;
            vp8_length = span;
            walk_state = PH_MATCHED;
          end else begin
            next_base = {1'b0, chunk_base} + {1'b0, span};
            if (next_base >= {1'b0, riff_total}) walk_state = PH_ENDED;
            else chunk_base = next_base[SIZE_W-1:0];
          end
        end
      end
    end
    file_len = {1'b0, byte_pos} + (POS_W+1)'(1);
    if (byte_pos != '1) byte_pos = byte_pos + POS_W'(1);
    if (beat.last_byte) begin
      res.found        = (walk_state == PH_MATCHED) && (file_len >= riff_total);
      res.chunk_offset = res.found ? vp8_offset : '0;
      res.chunk_length = res.found ? vp8_length : '0;
      located_q.push_back(res);
      clear_locator();
    end
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (located_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result: expected none, actual found %0d offset %0d length %0d",
               $time, got.found, got.chunk_offset, got.chunk_length);
      return;
    end
    want = located_q.pop_front();
    if (got.found !== want.found) begin
      mismatches++;
      $display("%0t: found: expected %0d, actual %0d", $time, want.found, got.found);
    end
    if (got.chunk_offset !== want.chunk_offset) begin
      mismatches++;
      $display("%0t: chunk_offset: expected %0d, actual %0d",
               $time, want.chunk_offset, got.chunk_offset);
    end
    if (got.chunk_length !== want.chunk_length) begin
      mismatches++;
      $display("%0t: chunk_length: expected %0d, actual %0d",
               $time, want.chunk_length, got.chunk_length);
    end
  endtask

  // handshake signals only move at the rising edge, so the falling edge sees
  // exactly what the next rising edge will take
  always @(negedge clk) begin
    if (!rst_n) begin
      clear_locator();
      located_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) track_byte(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    awaiting = located_q.size();
  end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import rvcl_pkg::*;

  // other chunk tags seen in real files, plus a near miss on the riff tag
  localparam logic [31:0] TAG_VP8L = 32'h5650_384C;
  localparam logic [31:0] TAG_ALPH = 32'h414C_5048;
  localparam logic [31:0] TAG_RIFX = 32'h5249_4658;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_BYTES  = 200;
  localparam int PHASE_FILES  = 5;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  int mismatches;
  int awaiting;
  int cycle_count;

  // traffic shaping
  int idle_pct;
  int stall_pct;
  int hold_token;
  int hold_seen;
  int hold_left;

  // file under construction and running totals
  logic [7:0] file_q[$];
  int         bytes_sent;
  int         files_sent;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  riff_vp8_chunk_locator_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  vp8_locate_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when the stimulus asks for one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_seen != hold_token) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void push_tag(input logic [31:0] tag);
    // tags go out in reading order, first character first
    file_q.push_back(tag[31:24]);
    file_q.push_back(tag[23:16]);
    file_q.push_back(tag[15:8]);
    file_q.push_back(tag[7:0]);
  endfunction

  function automatic void push_le32(input logic [31:0] value);
    file_q.push_back(value[7:0]);
    file_q.push_back(value[15:8]);
    file_q.push_back(value[23:16]);
    file_q.push_back(value[31:24]);
  endfunction

  // one beat; called right after a rising edge, returns right after the edge
  // that took it
  task automatic send_beat(input logic [7:0] value, input logic last);
    logic taken;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: value, last_byte: last};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  // stream the file, last-byte mark on its final beat
  task automatic send_file();
    foreach (file_q[i]) send_beat(file_q[i], i == file_q.size() - 1);
    bytes_sent += file_q.size();
    files_sent++;
    file_q.delete();
  endtask

  task automatic build_random_file();
    logic [7:0]  body_q[$];
    logic [31:0] chunk_tag;
    logic [31:0] size_word;
    logic [31:0] payload;
    int          shape;
    int          cut;
    int          idx;
    shape = $urandom_range(99);
    file_q.delete();

    // plain noise, sometimes behind a valid riff tag
    if (shape >= 95) begin
      if ($urandom_range(1)) push_tag(TAG_RIFF);
      repeat ($urandom_range(16, 1)) file_q.push_back(8'($urandom));
      return;
    end

    // chunk list first, so the payload size is known for the header
    for (int c = $urandom_range(3); c > 0; c--) begin
      case ($urandom_range(5))
        0, 1:    chunk_tag = TAG_VP8;
        2:       chunk_tag = TAG_VP8 ^ (32'h1 << $urandom_range(31));
        3:       chunk_tag = TAG_VP8L;
        4:       chunk_tag = TAG_ALPH;
        default: chunk_tag = $urandom;
      endcase
      size_word = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(9);
      push_tag(chunk_tag);
      push_le32(size_word);
      repeat (size_word + size_word[0]) file_q.push_back(8'($urandom));
    end

    // a chunk whose size field is near the 32-bit limit
    if (shape >= 90) begin
      case ($urandom_range(2))
        0:       size_word = 32'hFFFF_FFFF;
        1:       size_word = 32'hFFFF_FFFE;
        default: size_word = $urandom | 32'h8000_0000;
      endcase
      push_tag($urandom_range(1) ? TAG_VP8 : TAG_ALPH);
      push_le32(size_word);
      repeat ($urandom_range(4)) file_q.push_back(8'($urandom));
    end

    body_q  = file_q;
    payload = 32'd4 + body_q.size();
    if (shape >= 90) begin
      if ($urandom_range(1)) payload = 32'hFFFF_FFFF;
    end else if (shape >= 85) begin
      // payload below the minimum, or exactly the webp tag alone
      payload = $urandom_range(4);
    end else if (shape >= 70 && shape < 75) begin
      // container longer than the file
      payload = payload + $urandom_range(20, 1);
    end else if (shape >= 60 && shape < 70 && payload > 16) begin
      // container ends inside the chunk list
      payload = payload - $urandom_range(12, 1);
    end

    file_q.delete();
    push_tag(TAG_RIFF);
    push_le32(payload);
    push_tag(TAG_WEBP);
    foreach (body_q[i]) file_q.push_back(body_q[i]);

    if (shape < 60 && $urandom_range(5) == 0) begin
      // trailing bytes past the container
      repeat ($urandom_range(6, 1)) file_q.push_back(8'($urandom));
    end else if (shape >= 75 && shape < 80) begin
      cut = $urandom_range(file_q.size() - 1, 1);
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else if (shape >= 80 && shape < 85) begin
      idx = $urandom_range(11);
      file_q[idx] = file_q[idx] ^ (8'h1 << $urandom_range(7));
    end
  endtask

  // random files until this phase has moved enough bytes and files
  task automatic run_phase(input int sender_idle, input int receiver_stall);
    int bytes_mark;
    int files_mark;
    idle_pct   = sender_idle;
    stall_pct <= receiver_stall;
    bytes_mark = bytes_sent;
    files_mark = files_sent;
    while (bytes_sent - bytes_mark < PHASE_BYTES || files_sent - files_mark < PHASE_FILES) begin
      build_random_file();
      send_file();
    end
  endtask

  initial begin
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // smallest complete file: one empty vp8 chunk right after the header
    push_tag(TAG_RIFF);
    push_le32(32'd12);
    push_tag(TAG_WEBP);
    push_tag(TAG_VP8);
    push_le32(32'd0);
    send_file();

    // file of a single byte
    file_q.push_back(8'hFF);
    send_file();

    // wrong riff tag, file ends with it
    push_tag(TAG_RIFX);
    send_file();

    // payload size below the webp tag
    push_tag(TAG_RIFF);
    push_le32(32'd3);
    push_tag(TAG_WEBP);
    send_file();

    // oversized size fields: vp8 chunk fits the huge container, file too short
    push_tag(TAG_RIFF);
    push_le32(32'hFFFF_FFFF);
    push_tag(TAG_WEBP);
    push_tag(TAG_VP8);
    push_le32(32'hFFFF_FFF2);
    send_file();

    // no idling at all
    run_phase(0, 0);

    // hold the result side off while single-byte files keep coming, so both
    // output entries fill and the input stalls
    idle_pct = 0;
    hold_token <= hold_token + 1;
    repeat (12) begin
      file_q.push_back(8'($urandom));
      send_file();
    end

    run_phase(87, 0);
    run_phase(0, 87);
    run_phase(15, 15);

    in_valid <= 1'b0;
    while (awaiting != 0) @(posedge clk);
    // let anything spurious still show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
